FILE: src/tlv_container_deframer_defines.svh
// ----------------------------------------------------------------------------
// tlv container deframer assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef TLV_CONTAINER_DEFRAMER_DEFINES_SVH
`define TLV_CONTAINER_DEFRAMER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define TLVD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tlvd check failed");

// next-cycle implication, sampled on clk, off during reset
`define TLVD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tlvd check failed");

`endif

FILE: src/tlvd_pkg.sv
// ----------------------------------------------------------------------------
// tlvd package
// types, codes and the header magic shared by the deframer modules
// ----------------------------------------------------------------------------
package tlvd_pkg;

    localparam int HEADER_BYTES      = 32;
    localparam int MAGIC_BYTES       = 16;
    localparam int MAGIC_TABLE_DEPTH = 32;
    localparam int MAGIC_IDX_W       = $clog2(MAGIC_TABLE_DEPTH);
    localparam int FIELD_BYTES       = 8;
    localparam int FIELD_CNT_W       = $clog2(FIELD_BYTES);
    localparam int WORD_W            = 64;

    // byte roles
    localparam logic [2:0] ROLE_HEADER  = 3'd0;
    localparam logic [2:0] ROLE_TAG     = 3'd1;
    localparam logic [2:0] ROLE_LENGTH  = 3'd2;
    localparam logic [2:0] ROLE_PAYLOAD = 3'd3;
    localparam logic [2:0] ROLE_IGNORED = 3'd4;

    // stream status
    localparam logic [1:0] ST_RUNNING   = 2'd0;
    localparam logic [1:0] ST_OK        = 2'd1;
    localparam logic [1:0] ST_BAD_MAGIC = 2'd2;
    localparam logic [1:0] ST_TRUNCATED = 2'd3;

    // "Armageddon", 6, 6, 6, 42, 30, then zeros
    localparam logic [7:0] MAGIC_TABLE [MAGIC_TABLE_DEPTH] = '{
        8'h41, 8'h72, 8'h6D, 8'h61, 8'h67, 8'h65, 8'h64, 8'h64,
        8'h6F, 8'h6E, 8'h06, 8'h06, 8'h06, 8'h2A, 8'h1E, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_final;
    } in_t;

    typedef struct packed {
        logic [2:0]               byte_role;
        logic                     record_ready;
        logic signed [WORD_W-1:0] record_tag;
        logic [WORD_W-1:0]        record_length;
        logic [WORD_W-1:0]        payload_offset;
        logic                     payload_end;
        logic [1:0]               status;
    } out_t;

    // classified byte handed from front to back
    typedef struct packed {
        logic [7:0]        data_byte;
        logic [2:0]        byte_role;
        logic              record_ready;
        logic [WORD_W-1:0] record_length;
        logic [WORD_W-1:0] payload_offset;
        logic              payload_end;
        logic [1:0]        status;
    } cmd_t;

    // queue read side as seen by the back end
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_head_t;

endpackage

FILE: src/tlvd_front.sv
// ----------------------------------------------------------------------------
// tlvd front end
// parses header and record framing, classifies each byte
// ----------------------------------------------------------------------------
module tlvd_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           byte_valid,
    input  logic           q_ready,
    input  tlvd_pkg::in_t  byte_data,
    output logic           push,
    output tlvd_pkg::cmd_t cmd
);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_TAG,
        PH_LENGTH,
        PH_PAYLOAD,
        PH_ERROR
    } phase_t;

    localparam logic [tlvd_pkg::FIELD_CNT_W-1:0] FC_LAST =
        tlvd_pkg::FIELD_CNT_W'(tlvd_pkg::FIELD_BYTES - 1);

    phase_t                          phase_reg, phase_next;
    logic [tlvd_pkg::FIELD_CNT_W-1:0] fc_reg, fc_next;
    logic [tlvd_pkg::WORD_W-1:0]     len_shift_reg, len_shift_next;
    logic [tlvd_pkg::WORD_W-1:0]     left_reg, left_next;
    logic [tlvd_pkg::WORD_W-1:0]     offset_reg, offset_next;
    logic                            err_reg, err_next;

    logic [tlvd_pkg::WORD_W-1:0] offset_inc;
    logic [tlvd_pkg::WORD_W-1:0] len_new;
    logic [tlvd_pkg::WORD_W-1:0] left_dec;
    logic [7:0]                  magic_byte;
    logic                        in_magic;

    assign push       = byte_valid && q_ready;
    assign offset_inc = offset_reg + tlvd_pkg::WORD_W'(1);
    assign len_new    = {byte_data.data_byte, len_shift_reg[tlvd_pkg::WORD_W-1:8]};
    assign left_dec   = left_reg - tlvd_pkg::WORD_W'(1);
    assign magic_byte = tlvd_pkg::MAGIC_TABLE[offset_reg[tlvd_pkg::MAGIC_IDX_W-1:0]];
    assign in_magic   = offset_reg < tlvd_pkg::WORD_W'(tlvd_pkg::MAGIC_BYTES);

    always_comb
    begin
        phase_next     = phase_reg;
        fc_next        = fc_reg;
        len_shift_next = len_shift_reg;
        left_next      = left_reg;
        err_next       = err_reg;
        offset_next    = offset_inc;

        cmd                = '0;
        cmd.data_byte      = byte_data.data_byte;
        cmd.byte_role      = tlvd_pkg::ROLE_IGNORED;
        cmd.status         = tlvd_pkg::ST_RUNNING;

        unique case (phase_reg)
            PH_HEADER:
            begin
                cmd.byte_role = tlvd_pkg::ROLE_HEADER;
                if (in_magic && byte_data.data_byte != magic_byte)
                begin
                    err_next   = 1'b1;
                    phase_next = PH_ERROR;
                end
                else if (offset_inc == tlvd_pkg::WORD_W'(tlvd_pkg::HEADER_BYTES))
                begin
                    phase_next = PH_TAG;
                    fc_next    = '0;
                end
            end
            PH_TAG:
            begin
                cmd.byte_role = tlvd_pkg::ROLE_TAG;
                fc_next       = fc_reg + 1'b1;
                if (fc_reg == FC_LAST)
                begin
                    phase_next = PH_LENGTH;
                end
            end
            PH_LENGTH:
            begin
                cmd.byte_role  = tlvd_pkg::ROLE_LENGTH;
                len_shift_next = len_new;
                fc_next        = fc_reg + 1'b1;
                if (fc_reg == FC_LAST)
                begin
                    cmd.record_ready   = 1'b1;
                    cmd.record_length  = len_new;
                    cmd.payload_offset = offset_inc;
                    if (len_new == '0)
                    begin
                        cmd.payload_end = 1'b1;
                        phase_next      = PH_TAG;
                    end
                    else
                    begin
                        left_next  = len_new;
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                cmd.byte_role = tlvd_pkg::ROLE_PAYLOAD;
                left_next     = left_dec;
                if (left_dec == '0)
                begin
                    cmd.payload_end = 1'b1;
                    phase_next      = PH_TAG;
                end
            end
            default:
            begin
                cmd.byte_role = tlvd_pkg::ROLE_IGNORED;
            end
        endcase

        if (byte_data.is_final)
        begin
            if (err_next)
                cmd.status = tlvd_pkg::ST_BAD_MAGIC;
            else if (phase_next == PH_TAG && fc_next == '0)
                cmd.status = tlvd_pkg::ST_OK;
            else
                cmd.status = tlvd_pkg::ST_TRUNCATED;
            // back to the header for the next container
            phase_next     = PH_HEADER;
            fc_next        = '0;
            len_shift_next = '0;
            left_next      = '0;
            err_next       = 1'b0;
            offset_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            fc_reg        <= '0;
            len_shift_reg <= '0;
            left_reg      <= '0;
            offset_reg    <= '0;
            err_reg       <= 1'b0;
        end
        else if (push)
        begin
            phase_reg     <= phase_next;
            fc_reg        <= fc_next;
            len_shift_reg <= len_shift_next;
            left_reg      <= left_next;
            offset_reg    <= offset_next;
            err_reg       <= err_next;
        end
    end

endmodule

FILE: src/tlvd_queue.sv
// ----------------------------------------------------------------------------
// tlvd queue
// two-entry fifo between front and back ends
// ----------------------------------------------------------------------------
module tlvd_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tlvd_pkg::cmd_t    push_cmd,
    output logic              q_ready,
    input  logic              pop,
    output tlvd_pkg::q_head_t head
);

    tlvd_pkg::cmd_t entry_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;

    assign q_ready    = count_reg != 2'd2;
    assign head.valid = count_reg != 2'd0;
    assign head.cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

FILE: src/tlvd_back.sv
// ----------------------------------------------------------------------------
// tlvd back end
// assembles the record tag and holds the result register
// ----------------------------------------------------------------------------
module tlvd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  tlvd_pkg::q_head_t head,
    output logic              pop,
    output logic              result_valid,
    input  logic              result_ready,
    output tlvd_pkg::out_t    result_data
);

    logic [tlvd_pkg::WORD_W-1:0] tag_shift_reg, tag_shift_next;
    logic                        out_valid_reg, out_valid_next;
    tlvd_pkg::out_t              out_reg, out_next;

    assign pop          = head.valid && (!out_valid_reg || result_ready);
    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;

    always_comb
    begin
        tag_shift_next = tag_shift_reg;
        if (head.cmd.byte_role == tlvd_pkg::ROLE_TAG)
            tag_shift_next = {head.cmd.data_byte, tag_shift_reg[tlvd_pkg::WORD_W-1:8]};
        // final byte clears assembly
        if (head.cmd.status != tlvd_pkg::ST_RUNNING)
            tag_shift_next = '0;

        out_next.byte_role      = head.cmd.byte_role;
        out_next.record_ready   = head.cmd.record_ready;
        out_next.record_tag     = head.cmd.record_ready ? tag_shift_reg : '0;
        out_next.record_length  = head.cmd.record_length;
        out_next.payload_offset = head.cmd.payload_offset;
        out_next.payload_end    = head.cmd.payload_end;
        out_next.status         = head.cmd.status;

        out_valid_next = pop || (out_valid_reg && !result_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_shift_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
                tag_shift_reg <= tag_shift_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            out_reg <= out_next;
    end

endmodule

FILE: src/tlv_container_deframer.sv
// ----------------------------------------------------------------------------
// tlv container deframer
// splits a byte stream into a checked header and tag/length/value records
// ----------------------------------------------------------------------------
//  channel   handshake                   payload
//  byte      byte_valid / byte_ready     byte_data   (in_t: data_byte, is_final)
//  result    result_valid / result_ready result_data (out_t: role, record, status)
//
//  one byte per cycle while the result side keeps up; each transaction yields exactly one result
//  result_valid rises once a byte has passed the queue, written at the
//  accepting edge, and then the back-end result register, written on pop
//  rst_n is asynchronous and returns the parser to the header phase
//  a stalled result side fills the queue; byte_ready drops only when the
//  queue holds two transactions and the result register is occupied
// ----------------------------------------------------------------------------
module tlv_container_deframer (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           byte_valid,
    output logic           byte_ready,
    input  tlvd_pkg::in_t  byte_data,
    output logic           result_valid,
    input  logic           result_ready,
    output tlvd_pkg::out_t result_data
);

    // front to queue
    logic              push;
    tlvd_pkg::cmd_t    push_cmd;
    // queue to back
    logic              pop;
    tlvd_pkg::q_head_t head;

    // front: header check, field counting, payload countdown, offsets
    tlvd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .q_ready    (byte_ready),
        .byte_data  (byte_data),
        .push       (push),
        .cmd        (push_cmd)
    );

    // queue decouples the parser from result back-pressure
    tlvd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .q_ready  (byte_ready),
        .pop      (pop),
        .head     (head)
    );

    // back: tag assembly and the result register
    tlvd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

endmodule

FILE: src/tlvd_checker.sv
// ----------------------------------------------------------------------------
// tlvd checker
// port-level properties of the deframer result channel
// ----------------------------------------------------------------------------
`include "tlv_container_deframer_defines.svh"

module tlvd_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           byte_ready,
    input logic           result_valid,
    input logic           result_ready,
    input tlvd_pkg::out_t result_data
);

    logic stalled;
    logic record_flag;
    logic end_flag;
    logic side_zero;
    logic role_length;
    logic empty_record;
    logic end_role_ok;

    assign stalled      = result_valid && !result_ready;
    assign record_flag  = result_valid && result_data.record_ready;
    assign end_flag     = result_valid && result_data.payload_end;
    assign side_zero    = result_data.record_tag == '0 && result_data.record_length == '0
                          && result_data.payload_offset == '0;
    assign role_length  = result_data.byte_role == tlvd_pkg::ROLE_LENGTH;
    assign empty_record = role_length && result_data.record_ready
                          && result_data.record_length == '0;
    assign end_role_ok  = result_data.byte_role == tlvd_pkg::ROLE_PAYLOAD || empty_record;

    // stalled result holds
    `TLVD_ASSERT_NEXT(a_result_hold, stalled, result_valid && $stable(result_data))
    // a record completes only on a length byte
    `TLVD_ASSERT_NOW(a_ready_role, record_flag, role_length)
    // record fields are zero outside record_ready
    `TLVD_ASSERT_NOW(a_side_zero, result_valid && !result_data.record_ready, side_zero)
    // payload end only on payload bytes or an empty record
    `TLVD_ASSERT_NOW(a_end_role, end_flag, end_role_ok)
    // input held off only while a result waits
    `TLVD_ASSERT_NOW(a_full_stall, !byte_ready, result_valid)

endmodule

bind tlv_container_deframer tlvd_checker u_tlvd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_ready   (byte_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data)
);
